[rtl/cflr_pkg.sv]
`default_nettype none
package cflr_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int LAST_INDEX  = FRAME_BYTES - 1;
  localparam int CRC_END     = FRAME_BYTES - 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_MARKER = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALIVE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STALE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SYNC   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BURST  = 3'd4;

  localparam logic [31:0] MARKER_RESET = 32'hCCAA55EE;
  localparam logic [15:0] ALIVE_RESET  = 16'd1500;
  localparam logic [15:0] STALE_RESET  = 16'd1000;
  localparam logic [7:0]  SYNC_RESET   = 8'd5;
  localparam logic [7:0]  BURST_RESET  = 8'd3;

  localparam logic [7:0]  RUN_MAX = 8'd255;
  localparam logic [15:0] MS_MAX  = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_GOOD    = 3'd0,
    ST_IDLE    = 3'd1,
    ST_MARKER  = 3'd2,
    ST_CRC     = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef struct packed {
    logic [31:0] frame_marker;
    logic [15:0] alive_timeout_ms;
    logic [15:0] stale_timeout_ms;
    logic [7:0]  sync_frames;
    logic [7:0]  bad_burst_min;
  } cfg_t;

  typedef struct packed {
    logic        last;
    logic        seen_nonzero;
    logic        seen_non_ff;
    logic [31:0] marker;
    logic [31:0] position;
    logic [15:0] speed;
    logic [15:0] accel;
    logic [7:0]  flags;
    logic [7:0]  rate;
    logic [15:0] crc_rx;
    logic [15:0] crc_calc;
  } frame_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] position;
    logic [15:0] speed;
    logic [15:0] accel;
    logic [7:0]  flags;
    logic [7:0]  rate;
    logic        synced;
    logic [31:0] crc_errors;
    logic [31:0] marker_errors;
    logic [31:0] checked;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/cflr_apb_regs.sv]
`default_nettype none
module cflr_apb_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output cflr_pkg::cfg_t           cfg
);

  logic [cflr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_marker     <= cflr_pkg::MARKER_RESET;
      cfg.alive_timeout_ms <= cflr_pkg::ALIVE_RESET;
      cfg.stale_timeout_ms <= cflr_pkg::STALE_RESET;
      cfg.sync_frames      <= cflr_pkg::SYNC_RESET;
      cfg.bad_burst_min    <= cflr_pkg::BURST_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        cflr_pkg::REG_MARKER: cfg.frame_marker     <= pwdata;
        cflr_pkg::REG_ALIVE:  cfg.alive_timeout_ms <= pwdata[15:0];
        cflr_pkg::REG_STALE:  cfg.stale_timeout_ms <= pwdata[15:0];
        cflr_pkg::REG_SYNC:   cfg.sync_frames      <= pwdata[7:0];
        cflr_pkg::REG_BURST:  cfg.bad_burst_min    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cflr_pkg::REG_MARKER: prdata = cfg.frame_marker;
      cflr_pkg::REG_ALIVE:  prdata = {16'd0, cfg.alive_timeout_ms};
      cflr_pkg::REG_STALE:  prdata = {16'd0, cfg.stale_timeout_ms};
      cflr_pkg::REG_SYNC:   prdata = {24'd0, cfg.sync_frames};
      cflr_pkg::REG_BURST:  prdata = {24'd0, cfg.bad_burst_min};
      default:              prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/cflr_frame_asm.sv]
`default_nettype none
module cflr_frame_asm (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   rx_byte,
  output cflr_pkg::frame_t  frame
);

  logic [cflr_pkg::IDX_W-1:0] byte_index;
  logic [7:0]                 frame_store [cflr_pkg::FRAME_BYTES];
  logic [15:0]                running_crc;
  logic                       seen_nonzero;
  logic                       seen_non_ff;
  logic                       last;

  assign last = (byte_index == cflr_pkg::IDX_W'(cflr_pkg::LAST_INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      running_crc  <= cflr_pkg::CRC_INIT;
      seen_nonzero <= 1'b0;
      seen_non_ff  <= 1'b0;
    end else if (step) begin
      if (last) begin
        byte_index   <= '0;
        running_crc  <= cflr_pkg::CRC_INIT;
        seen_nonzero <= 1'b0;
        seen_non_ff  <= 1'b0;
      end else begin
        byte_index <= byte_index + 1'b1;
        if (byte_index < cflr_pkg::IDX_W'(cflr_pkg::CRC_END)) begin
          running_crc <= cflr_pkg::crc_byte(running_crc, rx_byte);
        end
        seen_nonzero <= seen_nonzero | (rx_byte != 8'h00);
        seen_non_ff  <= seen_non_ff | (rx_byte != 8'hFF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      frame_store[byte_index] <= rx_byte;
    end
  end

  // view of the frame as it stands once the current (final) byte is added
  always_comb begin
    frame.last         = last;
    frame.seen_nonzero = seen_nonzero | (rx_byte != 8'h00);
    frame.seen_non_ff  = seen_non_ff | (rx_byte != 8'hFF);
    frame.marker       = {frame_store[3], frame_store[2], frame_store[1], frame_store[0]};
    frame.position     = {frame_store[7], frame_store[6], frame_store[5], frame_store[4]};
    frame.speed        = {frame_store[9], frame_store[8]};
    frame.accel        = {frame_store[11], frame_store[10]};
    frame.flags        = frame_store[12];
    frame.rate         = frame_store[13];
    frame.crc_rx       = {rx_byte, frame_store[14]};
    frame.crc_calc     = running_crc;
  end

endmodule
`default_nettype wire

[rtl/cflr_link_mon.sv]
`default_nettype none
module cflr_link_mon (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              judge,
  input  wire logic              tick,
  input  wire logic              clear,
  input  wire logic              alive_level,
  input  wire cflr_pkg::cfg_t    cfg,
  input  wire cflr_pkg::frame_t  frame,
  output cflr_pkg::result_t      result
);

  logic [31:0] held_position, held_position_next;
  logic [15:0] held_speed, held_speed_next;
  logic [15:0] held_accel, held_accel_next;
  logic [7:0]  held_flags, held_flags_next;
  logic [7:0]  held_rate, held_rate_next;
  logic        synced_flag, synced_flag_next;
  logic [7:0]  good_run, good_run_next;
  logic [7:0]  bad_run, bad_run_next;
  logic [31:0] crc_error_total, crc_error_total_next;
  logic [31:0] marker_error_total, marker_error_total_next;
  logic [31:0] checked_total, checked_total_next;
  logic [15:0] ms_since_good, ms_since_good_next;
  logic        ever_good, ever_good_next;
  logic [15:0] ms_since_edge, ms_since_edge_next;
  logic        prev_alive_level, prev_alive_level_next;
  logic        alive_level_known, alive_level_known_next;

  cflr_pkg::status_t status;
  logic              present;
  logic [7:0]        bad_inc;
  logic [7:0]        good_inc;
  logic              count_err;

  assign present   = (ms_since_edge < cfg.alive_timeout_ms);
  assign bad_inc   = (synced_flag && (bad_run != cflr_pkg::RUN_MAX)) ? bad_run + 8'd1 : bad_run;
  assign good_inc  = (good_run != cflr_pkg::RUN_MAX) ? good_run + 8'd1 : good_run;
  assign count_err = synced_flag && (bad_inc >= cfg.bad_burst_min);

  always_comb begin
    held_position_next      = held_position;
    held_speed_next         = held_speed;
    held_accel_next         = held_accel;
    held_flags_next         = held_flags;
    held_rate_next          = held_rate;
    synced_flag_next        = synced_flag;
    good_run_next           = good_run;
    bad_run_next            = bad_run;
    crc_error_total_next    = crc_error_total;
    marker_error_total_next = marker_error_total;
    checked_total_next      = checked_total;
    ms_since_good_next      = ms_since_good;
    ever_good_next          = ever_good;
    ms_since_edge_next      = ms_since_edge;
    prev_alive_level_next   = prev_alive_level;
    alive_level_known_next  = alive_level_known;
    status                  = cflr_pkg::ST_GOOD;

    if (judge) begin
      if (!present) begin
        synced_flag_next = 1'b0;
        good_run_next    = '0;
        bad_run_next     = '0;
        status           = cflr_pkg::ST_MISSING;
      end else begin
        checked_total_next = checked_total + 32'd1;
        if (!frame.seen_nonzero || !frame.seen_non_ff) begin
          bad_run_next = bad_inc;
          status       = cflr_pkg::ST_IDLE;
        end else if (frame.marker != cfg.frame_marker) begin
          bad_run_next = bad_inc;
          if (count_err) begin
            marker_error_total_next = marker_error_total + 32'd1;
          end
          status = cflr_pkg::ST_MARKER;
        end else if (frame.crc_rx != frame.crc_calc) begin
          bad_run_next = bad_inc;
          if (count_err) begin
            crc_error_total_next = crc_error_total + 32'd1;
          end
          status = cflr_pkg::ST_CRC;
        end else begin
          bad_run_next       = '0;
          held_position_next = frame.position;
          held_speed_next    = frame.speed;
          held_accel_next    = frame.accel;
          held_flags_next    = frame.flags;
          held_rate_next     = frame.rate;
          ms_since_good_next = '0;
          ever_good_next     = 1'b1;
          if (!synced_flag) begin
            good_run_next = good_inc;
            if (good_inc >= cfg.sync_frames) begin
              synced_flag_next        = 1'b1;
              marker_error_total_next = '0;
              crc_error_total_next    = '0;
            end
          end
        end
      end
    end else if (tick) begin
      if (!alive_level_known || (alive_level != prev_alive_level)) begin
        ms_since_edge_next = '0;
      end else if (ms_since_edge != cflr_pkg::MS_MAX) begin
        ms_since_edge_next = ms_since_edge + 16'd1;
      end
      prev_alive_level_next  = alive_level;
      alive_level_known_next = 1'b1;
      if (ms_since_good != cflr_pkg::MS_MAX) begin
        ms_since_good_next = ms_since_good + 16'd1;
      end
      if (ever_good && (ms_since_good_next > cfg.stale_timeout_ms)) begin
        synced_flag_next = 1'b0;
        good_run_next    = '0;
      end
    end else if (clear) begin
      crc_error_total_next    = '0;
      marker_error_total_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_position      <= '0;
      held_speed         <= '0;
      held_accel         <= '0;
      held_flags         <= '0;
      held_rate          <= '0;
      synced_flag        <= 1'b0;
      good_run           <= '0;
      bad_run            <= '0;
      crc_error_total    <= '0;
      marker_error_total <= '0;
      checked_total      <= '0;
      ms_since_good      <= '0;
      ever_good          <= 1'b0;
      ms_since_edge      <= '0;
      prev_alive_level   <= 1'b0;
      alive_level_known  <= 1'b0;
    end else begin
      held_position      <= held_position_next;
      held_speed         <= held_speed_next;
      held_accel         <= held_accel_next;
      held_flags         <= held_flags_next;
      held_rate          <= held_rate_next;
      synced_flag        <= synced_flag_next;
      good_run           <= good_run_next;
      bad_run            <= bad_run_next;
      crc_error_total    <= crc_error_total_next;
      marker_error_total <= marker_error_total_next;
      checked_total      <= checked_total_next;
      ms_since_good      <= ms_since_good_next;
      ever_good          <= ever_good_next;
      ms_since_edge      <= ms_since_edge_next;
      prev_alive_level   <= prev_alive_level_next;
      alive_level_known  <= alive_level_known_next;
    end
  end

  always_comb begin
    result.status        = status;
    result.position      = held_position_next;
    result.speed         = held_speed_next;
    result.accel         = held_accel_next;
    result.flags         = held_flags_next;
    result.rate          = held_rate_next;
    result.synced        = synced_flag_next;
    result.crc_errors    = crc_error_total_next;
    result.marker_errors = marker_error_total_next;
    result.checked       = checked_total_next;
  end

endmodule
`default_nettype wire

[rtl/crc_framed_link_receiver_unit.sv]
`default_nettype none
// An item is held in the input register, its result in the result register. Throughput is one
// item per cycle, but an item ending a frame waits while an earlier result is stalled; the CRC
// byte update and the frame check each fit in the single logic stage between the registers.
// Only the 16th byte of a frame yields a result; other items are absorbed.
// Reset (rst, synchronous) restores the registers to defaults and clears all link state.
module crc_framed_link_receiver_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               alive_level,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              frame_status,
  output logic signed [31:0]      position_cdeg,
  output logic signed [15:0]      speed_ddeg,
  output logic signed [15:0]      accel_ddeg,
  output logic [7:0]              flag_bits,
  output logic [7:0]              loop_rate,
  output logic                    sync_locked,
  output logic [31:0]             crc_errors,
  output logic [31:0]             marker_errors,
  output logic [31:0]             frames_checked,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic       in_q_valid;
  logic [1:0] action_q;
  logic [7:0] byte_q;
  logic       level_q;
  logic       in_take;
  logic       gives_result;
  logic       advance;
  logic       is_byte;

  cflr_pkg::cfg_t    cfg;
  cflr_pkg::frame_t  frame;
  cflr_pkg::result_t result;
  cflr_pkg::result_t out_q;

  assign is_byte      = (action_q == cflr_pkg::ACT_BYTE);
  assign gives_result = is_byte && frame.last;
  assign advance      = in_q_valid && (!out_valid || !out_stall || !gives_result);
  assign in_stall     = in_q_valid && !advance;
  assign in_take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_q <= action;
      byte_q   <= rx_byte;
      level_q  <= alive_level;
    end
  end

  cflr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cflr_frame_asm u_asm (
    .clk     (clk),
    .rst     (rst),
    .step    (advance && is_byte),
    .rx_byte (byte_q),
    .frame   (frame)
  );

  cflr_link_mon u_mon (
    .clk         (clk),
    .rst         (rst),
    .judge       (advance && gives_result),
    .tick        (advance && (action_q == cflr_pkg::ACT_TICK)),
    .clear       (advance && (action_q == cflr_pkg::ACT_CLEAR)),
    .alive_level (level_q),
    .cfg         (cfg),
    .frame       (frame),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && gives_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && gives_result) begin
      out_q <= result;
    end
  end

  assign frame_status   = out_q.status;
  assign position_cdeg  = $signed(out_q.position);
  assign speed_ddeg     = $signed(out_q.speed);
  assign accel_ddeg     = $signed(out_q.accel);
  assign flag_bits      = out_q.flags;
  assign loop_rate      = out_q.rate;
  assign sync_locked    = out_q.synced;
  assign crc_errors     = out_q.crc_errors;
  assign marker_errors  = out_q.marker_errors;
  assign frames_checked = out_q.checked;

endmodule
`default_nettype wire
